@@ src/krt_pkg.sv @@
// Shared constants, codes and types of the keyed record table.
// Used by the scan controller, the top level with its slot memory wiring, the checker and the testbench.
package krt_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int PTR_W         = $clog2(TABLE_DEPTH + 1);
  localparam int PAY_W         = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int CNT_W         = 7;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_PRUNE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      stamp;
    logic [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/krt_req_if.sv @@
// Request channel: one beat carries kind, key, stamp and payload.
// Depends on nothing.
interface krt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [31:0] stamp;
  logic [31:0] payload;

  modport source (output valid, kind, key, stamp, payload, input ready);
  modport sink (input valid, kind, key, stamp, payload, output ready);
endinterface

@@ src/krt_rsp_if.sv @@
// Result channel: one beat carries status, value, the found record and the entry count.
// Depends on nothing.
interface krt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;
  logic [31:0] found_stamp;
  logic [31:0] found_payload;
  logic [6:0]  entry_count;

  modport source (output valid, status, value, found_stamp, found_payload, entry_count,
                  input ready);
  modport sink (input valid, status, value, found_stamp, found_payload, entry_count,
                output ready);
endinterface

@@ src/krt_slot_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module krt_slot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/krt_scan.sv @@
// Request sequencer: sweeps the slot memory, keeps the valid bits and the record count,
// and builds the result beat. Depends on krt_pkg, krt_req_if and krt_rsp_if.
module krt_scan (
  input  logic              clk,
  input  logic              rst_n,
  krt_req_if.sink           in_req,
  krt_rsp_if.source         out_rsp,
  input  logic [31:0]       age_limit,
  output krt_pkg::ram_req_t ram_req,
  input  krt_pkg::slot_t    ram_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [31:0]                     key_r, key_nxt;
  logic [31:0]                     stamp_r, stamp_nxt;
  logic [krt_pkg::PAY_W-1:0]       pay_r, pay_nxt;
  logic [31:0]                     bound_r, bound_nxt;
  logic [krt_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic [krt_pkg::IDX_W-1:0]       dat_idx_r, dat_idx_nxt;
  logic [krt_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [krt_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            hit_r, hit_nxt;
  logic [krt_pkg::IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  krt_pkg::slot_t                  hit_slot_r, hit_slot_nxt;
  logic                            free_ok_r, free_ok_nxt;
  logic [krt_pkg::IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic [krt_pkg::PTR_W-1:0]       removed_r, removed_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic [31:0]                     out_value_r, out_value_nxt;
  logic [31:0]                     out_fstamp_r, out_fstamp_nxt;
  logic [31:0]                     out_fpay_r, out_fpay_nxt;
  logic [krt_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;

  logic cur_valid;
  logic match;
  logic scan_last;
  logic out_free;

  assign cur_valid = valid_r[dat_idx_r];
  assign match     = rd_pend_r && cur_valid && (ram_rdata.key == key_r);
  assign scan_last = rd_pend_r &&
                     (dat_idx_r == krt_pkg::IDX_W'(krt_pkg::TABLE_DEPTH - 1));
  assign out_free  = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    stamp_nxt      = stamp_r;
    pay_nxt        = pay_r;
    bound_nxt      = bound_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_pend_nxt    = rd_pend_r;
    dat_idx_nxt    = dat_idx_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_slot_nxt   = hit_slot_r;
    free_ok_nxt    = free_ok_r;
    free_idx_nxt   = free_idx_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_fstamp_nxt = out_fstamp_r;
    out_fpay_nxt   = out_fpay_r;
    out_count_nxt  = out_count_r;

    ram_req.we      = 1'b0;
    ram_req.waddr   = free_idx_r;
    ram_req.wdata   = '{key: key_r, stamp: stamp_r, payload: pay_r};
    ram_req.re      = 1'b0;
    ram_req.raddr   = rd_ptr_r[krt_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt    = in_req.kind;
          key_nxt     = in_req.key;
          stamp_nxt   = in_req.stamp;
          pay_nxt     = in_req.payload[krt_pkg::PAY_W-1:0];
          bound_nxt   = in_req.stamp - age_limit;
          rd_ptr_nxt  = '0;
          rd_pend_nxt = 1'b0;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          removed_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_nxt = 1'b0;
        if (rd_ptr_r < krt_pkg::PTR_W'(krt_pkg::TABLE_DEPTH)) begin
          ram_req.re  = 1'b1;
          rd_pend_nxt = 1'b1;
          dat_idx_nxt = rd_ptr_r[krt_pkg::IDX_W-1:0];
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (kind_r == krt_pkg::KIND_PRUNE) begin
            if (cur_valid && (ram_rdata.stamp < bound_r)) begin
              valid_nxt[dat_idx_r] = 1'b0;
              removed_nxt          = removed_r + 1'b1;
            end
          end else begin
            if (!cur_valid && !free_ok_r) begin
              free_ok_nxt  = 1'b1;
              free_idx_nxt = dat_idx_r;
            end
            if (match) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = dat_idx_r;
              hit_slot_nxt = ram_rdata;
            end
          end
        end
        if ((match && (kind_r != krt_pkg::KIND_PRUNE)) || scan_last) begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_nxt = krt_pkg::ST_OK;
          out_value_nxt  = '0;
          out_fstamp_nxt = '0;
          out_fpay_nxt   = '0;
          case (kind_r)
            krt_pkg::KIND_UPDATE: begin
              if (hit_r) begin
                if (stamp_r > hit_slot_r.stamp) begin
                  out_value_nxt = stamp_r - hit_slot_r.stamp;
                  ram_req.we    = 1'b1;
                  ram_req.waddr = hit_idx_r;
                end else begin
                  out_status_nxt = krt_pkg::ST_STALE;
                end
              end else if (free_ok_r) begin
                ram_req.we              = 1'b1;
                ram_req.waddr           = free_idx_r;
                valid_nxt[free_idx_r]   = 1'b1;
                count_nxt               = count_r + 1'b1;
                out_value_nxt           = stamp_r;
              end else begin
                out_status_nxt = krt_pkg::ST_FULL;
              end
            end
            krt_pkg::KIND_LOOKUP: begin
              if (hit_r) begin
                out_fstamp_nxt = hit_slot_r.stamp;
                out_fpay_nxt   = 32'(hit_slot_r.payload);
              end else begin
                out_status_nxt = krt_pkg::ST_MISS;
              end
            end
            krt_pkg::KIND_DELETE: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                count_nxt            = count_r - 1'b1;
              end else begin
                out_status_nxt = krt_pkg::ST_MISS;
              end
            end
            default: begin
              out_value_nxt = 32'(removed_r);
              count_nxt     = count_r - krt_pkg::CNT_W'(removed_r);
            end
          endcase
          out_count_nxt = count_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      rd_pend_r   <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      hit_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      hit_r       <= hit_nxt;
      free_ok_r   <= free_ok_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    stamp_r      <= stamp_nxt;
    pay_r        <= pay_nxt;
    bound_r      <= bound_nxt;
    dat_idx_r    <= dat_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_fstamp_r <= out_fstamp_nxt;
    out_fpay_r   <= out_fpay_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.value         = out_value_r;
  assign out_rsp.found_stamp   = out_fstamp_r;
  assign out_rsp.found_payload = out_fpay_r;
  assign out_rsp.entry_count   = out_count_r;

endmodule

@@ src/keyed_record_table_with_aging.sv @@
// Top level of the keyed record table: age limit register, slot memory and sequencer.
// Depends on krt_pkg, krt_req_if, krt_rsp_if, krt_slot_ram and krt_scan.
//
// The table holds up to 64 records of key, stamp and payload in one synchronous memory,
// with a valid bit per slot in flip-flops, so no clearing pass is needed after reset.
// One request is handled at a time. Each request sweeps the memory through its single
// read port, one slot per cycle: an update, lookup or delete that finds its key stops
// at that slot, otherwise the sweep covers all 64 slots, so prunes and misses always
// sweep the whole table. The finished result waits in an output register, so the next
// request is taken while it is still pending. The age limit is to be written through
// cfg_wr_en and cfg_wr_data only while no request is in flight; the block itself does
// not enforce this.
module keyed_record_table_with_aging (
  input  logic        clk,
  input  logic        rst_n,
  krt_req_if.sink     in_req,
  krt_rsp_if.source   out_rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0]       age_limit_r;
  krt_pkg::ram_req_t ram_req;
  krt_pkg::slot_t    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= '0;
    end else if (cfg_wr_en) begin
      age_limit_r <= cfg_wr_data;
    end
  end

  krt_slot_ram #(
    .WIDTH($bits(krt_pkg::slot_t)),
    .DEPTH(krt_pkg::TABLE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  krt_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .age_limit(age_limit_r),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while a sweep is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status == krt_pkg::ST_FULL) |->
      (out_rsp.entry_count == krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)))
    else $error("table reported full with free slots");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != krt_pkg::ST_OK) |->
      (out_rsp.value == '0) && (out_rsp.found_stamp == '0) &&
      (out_rsp.found_payload == '0))
    else $error("failed request carries nonzero result fields");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_req.ready)
    else $error("slot memory written outside a request");

endmodule

@@ bench/krt_checker.sv @@
// Result checker for the keyed record table: watches the request, result and age limit ports,
// keeps its own copy of the table, and compares every result beat against the predicted one.
// Depends on krt_pkg, krt_req_if and krt_rsp_if.
module krt_checker
  import krt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  krt_req_if          req,
  krt_rsp_if          rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          results_seen,
  output int          backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      value;
    logic [31:0]      fstamp;
    logic [31:0]      fpay;
    logic [CNT_W-1:0] count;
  } answer_t;

  answer_t          answers_q[$];
  logic [31:0]      rec_key   [TABLE_DEPTH];
  logic [31:0]      rec_stamp [TABLE_DEPTH];
  logic [PAY_W-1:0] rec_pay   [TABLE_DEPTH];
  bit               rec_used  [TABLE_DEPTH];
  int unsigned      live;
  logic [31:0]      age_limit_q;
  int               fails;
  int               seen;

  initial begin
    fails = 0;
    seen = 0;
    live = 0;
    age_limit_q = '0;
    foreach (rec_used[i]) rec_used[i] = 1'b0;
  end

  function automatic answer_t apply_request(input logic [1:0] kind, input logic [31:0] key,
                                            input logic [31:0] stamp, input logic [31:0] pay);
    answer_t     a;
    int          hit;
    int          room;
    logic [31:0] bound;
    int unsigned removed;
    a = '0;
    a.status = ST_OK;
    hit = -1;
    room = -1;
    removed = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (rec_used[i] && rec_key[i] == key && hit < 0) hit = i;
      if (!rec_used[i] && room < 0) room = i;
    end
    case (kind)
      KIND_UPDATE: begin
        if (hit >= 0) begin
          if (stamp > rec_stamp[hit]) begin
            a.value = stamp - rec_stamp[hit];
            rec_stamp[hit] = stamp;
            rec_pay[hit] = pay[PAY_W-1:0];
          end else begin
            a.status = ST_STALE;
          end
        end else if (room >= 0) begin
          rec_key[room] = key;
          rec_stamp[room] = stamp;
          rec_pay[room] = pay[PAY_W-1:0];
          rec_used[room] = 1'b1;
          live++;
          a.value = stamp;
        end else begin
          a.status = ST_FULL;
        end
      end
      KIND_LOOKUP: begin
        if (hit >= 0) begin
          a.fstamp = rec_stamp[hit];
          a.fpay = 32'(rec_pay[hit]);
        end else begin
          a.status = ST_MISS;
        end
      end
      KIND_DELETE: begin
        if (hit >= 0) begin
          rec_used[hit] = 1'b0;
          live--;
        end else begin
          a.status = ST_MISS;
        end
      end
      default: begin
        bound = stamp - age_limit_q;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (rec_used[i] && rec_stamp[i] < bound) begin
            rec_used[i] = 1'b0;
            removed++;
          end
        end
        live -= removed;
        a.value = removed;
      end
    endcase
    a.count = CNT_W'(live);
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: result beat %0d: %s", $time, seen, what);
    fails++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      foreach (rec_used[i]) rec_used[i] = 1'b0;
      live = 0;
      age_limit_q = '0;
      answers_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch("arrived with no request waiting for it");
        end else begin
          want = answers_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.value !== want.value)
            report_mismatch($sformatf("value %h, expected %h", rsp.value, want.value));
          if (rsp.found_stamp !== want.fstamp)
            report_mismatch($sformatf("found_stamp %h, expected %h",
                                      rsp.found_stamp, want.fstamp));
          if (rsp.found_payload !== want.fpay)
            report_mismatch($sformatf("found_payload %h, expected %h",
                                      rsp.found_payload, want.fpay));
          if (rsp.entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      rsp.entry_count, want.count));
        end
        seen++;
      end
      if (req.valid && req.ready)
        answers_q.push_back(apply_request(req.kind, req.key, req.stamp, req.payload));
      if (cfg_wr_en) age_limit_q = cfg_wr_data;
    end
    fail_count <= fails;
    results_seen <= seen;
    backlog <= answers_q.size();
  end

endmodule

@@ bench/tb_keyed_record_table_with_aging.sv @@
// Testbench top for the keyed record table: clock, reset, request and age limit stimulus,
// random result back-pressure and the final verdict.
// Depends on krt_pkg, krt_req_if, krt_rsp_if, krt_checker and the block itself.
module tb_keyed_record_table_with_aging;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int LIMIT   = 800_000;
  localparam int GAP_MAX = 12;
  localparam int POOL    = 96;
  localparam int PHASES  = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          fail_count;
  int          results_seen;
  int          backlog;
  int          sent_cnt;
  int          cycle_cnt;
  bit          calm_in;
  bit          calm_out;
  logic [31:0] clock_now;
  logic [31:0] key_pool [POOL];
  logic [31:0] age_plan [PHASES];

  krt_req_if req_ch();
  krt_rsp_if rsp_ch();

  keyed_record_table_with_aging DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  krt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .backlog      (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** keyed_record_table_with_aging: FAILED **");
    $finish;
  end

  task automatic send(input logic [1:0] kind, input logic [31:0] key,
                      input logic [31:0] stamp, input logic [31:0] pay);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, GAP_MAX);
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.key     <= key;
    req_ch.stamp   <= stamp;
    req_ch.payload <= pay;
    do @(posedge clk); while (!req_ch.ready);
    sent_cnt++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_seen != sent_cnt);
  endtask

  task automatic write_age(input logic [31:0] age);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= age;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic mixed_item();
    int          r;
    logic [31:0] key;
    logic [31:0] stamp;
    r = $urandom_range(0, 99);
    clock_now += $urandom_range(0, 40);
    key = key_pool[$urandom_range(0, POOL - 1)];
    if (r < 8) begin
      send(2'($urandom), $urandom, $urandom, $urandom);
    end else if (r < 52) begin
      stamp = ($urandom_range(0, 3) == 0) ? $urandom : clock_now - $urandom_range(0, 300);
      send(KIND_UPDATE, key, stamp, $urandom);
    end else if (r < 80) begin
      send(KIND_LOOKUP, key, $urandom, $urandom);
    end else if (r < 95) begin
      send(KIND_DELETE, key, $urandom, $urandom);
    end else begin
      stamp = ($urandom_range(0, 3) == 0) ? $urandom : clock_now;
      send(KIND_PRUNE, key, stamp, $urandom);
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    sent_cnt = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.kind    <= KIND_UPDATE;
    req_ch.key     <= '0;
    req_ch.stamp   <= '0;
    req_ch.payload <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL; i++)
      key_pool[i] = (i % 2 == 0) ? $urandom : key_pool[i - 1] ^ (32'd1 << $urandom_range(0, 31));
    age_plan = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd50, $urandom, 32'd2000, 32'd1,
                 $urandom_range(0, 300), 32'h8000_0000, 32'd100};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(KIND_LOOKUP, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_DELETE, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_PRUNE, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_UPDATE, 32'h0000_0000, 32'd100, 32'h0000_0000);
    send(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_LOOKUP, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send(KIND_UPDATE, 32'h0000_0000, 32'd100, 32'h1111_1111);
    send(KIND_UPDATE, 32'h0000_0000, 32'd50, 32'h2222_2222);
    send(KIND_UPDATE, 32'h0000_0000, 32'd300, 32'hA5A5_A5A5);
    send(KIND_LOOKUP, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_UPDATE, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send(KIND_DELETE, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_DELETE, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_LOOKUP, 32'h0000_0000, 32'd0, 32'd0);
    send(KIND_UPDATE, 32'h1234_5678, 32'd0, 32'h5A5A_5A5A);
    send(KIND_PRUNE, 32'h0000_0000, 32'd1, 32'd0);
    send(KIND_LOOKUP, 32'h1234_5678, 32'd0, 32'd0);
    send(KIND_PRUNE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_age(age_plan[ph]);
      clock_now = $urandom;
      if (ph % 5 == 0) begin
        repeat (70) send(KIND_UPDATE, $urandom, clock_now - $urandom_range(0, 200), $urandom);
        repeat (75) mixed_item();
      end else begin
        repeat (145) mixed_item();
      end
    end

    settle();
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("** keyed_record_table_with_aging: PASSED **");
    end else begin
      $display("** keyed_record_table_with_aging: FAILED **");
    end
    $finish;
  end

endmodule
